>>> src/dpds_pkg.sv
package dpds_pkg;

  // Field widths
  localparam int ENC_BITS       = 20;
  localparam int GAIN_FRAC_BITS = 20;
  localparam int TGT_W          = 16;
  localparam int ERR_W          = ENC_BITS + 1;
  localparam int DER_W          = ERR_W + 1;
  localparam int INT_W          = 32;
  localparam int GAIN_W         = GAIN_FRAC_BITS + 2;
  localparam int SUM_W          = GAIN_W + INT_W + 3;
  localparam int STALL_W        = 3;
  localparam int LIM_W          = 7;
  localparam int DRV_W          = 8;

  // Stream and configuration widths
  localparam int IN_W       = 48;
  localparam int OUT_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FWD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIFT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 2'd3;

  // Thresholds
  localparam int BAND_HI_MIN  = 1200;
  localparam int BAND_MID_MIN = 500;
  localparam int ILIM_HI      = 80;
  localparam int ILIM_LO      = 50;
  localparam int STALL_ERR    = 150;
  localparam int STALL_MAX    = 7;
  localparam int STALL_TRIP   = 5;
  localparam int ARM_ERR      = 180;
  localparam int HOLD_ERR     = 100;
  localparam int DRV_POS_MAX  = 125;
  localparam int DRV_NEG_MAX  = 127;

  // Gains, unsigned with GAIN_FRAC_BITS fraction bits, rounded to nearest
  localparam longint ONE = longint'(1) << GAIN_FRAC_BITS;

  localparam logic [GAIN_W-1:0] KP_L_HI  = GAIN_W'((39 * ONE + 50) / 100);
  localparam logic [GAIN_W-1:0] KP_L_MID = GAIN_W'((6 * ONE + 5) / 10);
  localparam logic [GAIN_W-1:0] KP_L_LO  = GAIN_W'((48 * ONE + 50) / 100);
  localparam logic [GAIN_W-1:0] KP_R_HI  = GAIN_W'((3 * ONE + 5) / 10);
  localparam logic [GAIN_W-1:0] KP_R_MID = GAIN_W'((5 * ONE + 5) / 10);
  localparam logic [GAIN_W-1:0] KP_R_LO  = GAIN_W'((4 * ONE + 5) / 10);
  localparam logic [GAIN_W-1:0] KI_L_HI  = GAIN_W'((5 * ONE + 50000) / 100000);
  localparam logic [GAIN_W-1:0] KI_L_MID = GAIN_W'((5 * ONE + 50000) / 100000);
  localparam logic [GAIN_W-1:0] KI_L_LO  = GAIN_W'((6 * ONE + 50000) / 100000);
  localparam logic [GAIN_W-1:0] KI_R_HI  = GAIN_W'((5 * ONE + 50000) / 100000);
  localparam logic [GAIN_W-1:0] KI_R_MID = GAIN_W'((4 * ONE + 50000) / 100000);
  localparam logic [GAIN_W-1:0] KI_R_LO  = GAIN_W'((6 * ONE + 50000) / 100000);
  localparam logic [GAIN_W-1:0] KD_HI    = GAIN_W'((3 * ONE + 1) / 2);
  localparam logic [GAIN_W-1:0] KD_MID   = GAIN_W'(3 * ONE);
  localparam logic [GAIN_W-1:0] KD_LO    = GAIN_W'(ONE);

  typedef enum logic [1:0] {
    BAND_HI,
    BAND_MID,
    BAND_LO
  } band_e;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [LIM_W-1:0]  lim;
  } lane_gain_t;

  // Lane control from the top level
  typedef struct packed {
    logic start;  // new move: clear integral and stall count, preload previous error
    logic run;    // item runs a control tick
    logic load;   // item moves into the first stage
    logic en1;
    logic en2;
  } lane_ctrl_t;

  // Lane status back to the top level
  typedef struct packed {
    logic                    reach;
    logic                    trip;
    logic signed [ERR_W-1:0] err;
  } lane_stat_t;

  function automatic band_e band_of(logic [TGT_W-1:0] tgt);
    band_e b;
    if (tgt >= TGT_W'(BAND_HI_MIN)) begin
      b = BAND_HI;
    end else if (tgt >= TGT_W'(BAND_MID_MIN)) begin
      b = BAND_MID;
    end else begin
      b = BAND_LO;
    end
    return b;
  endfunction

  function automatic lane_gain_t gain_left(band_e b);
    lane_gain_t g;
    case (b)
      BAND_HI:  g = '{kp: KP_L_HI,  ki: KI_L_HI,  kd: KD_HI,  lim: LIM_W'(ILIM_HI)};
      BAND_MID: g = '{kp: KP_L_MID, ki: KI_L_MID, kd: KD_MID, lim: LIM_W'(ILIM_LO)};
      default:  g = '{kp: KP_L_LO,  ki: KI_L_LO,  kd: KD_LO,  lim: LIM_W'(ILIM_LO)};
    endcase
    return g;
  endfunction

  function automatic lane_gain_t gain_right(band_e b);
    lane_gain_t g;
    case (b)
      BAND_HI:  g = '{kp: KP_R_HI,  ki: KI_R_HI,  kd: KD_HI,  lim: LIM_W'(ILIM_HI)};
      BAND_MID: g = '{kp: KP_R_MID, ki: KI_R_MID, kd: KD_MID, lim: LIM_W'(ILIM_LO)};
      default:  g = '{kp: KP_R_LO,  ki: KI_R_LO,  kd: KD_LO,  lim: LIM_W'(ILIM_LO)};
    endcase
    return g;
  endfunction

endpackage

>>> src/dpds_lane.sv
// One PID lane: error, integral, derivative and stall state, then the
// product stage and the truncated, clipped drive.
module dpds_lane (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  dpds_pkg::lane_ctrl_t                     ctrl_i,
  input  logic [dpds_pkg::TGT_W-1:0]               tgt_i,
  input  logic signed [dpds_pkg::ENC_BITS-1:0]     enc_i,
  input  dpds_pkg::lane_gain_t                     gain_i,
  output dpds_pkg::lane_stat_t                     stat_o,
  output logic signed [dpds_pkg::DRV_W-1:0]        drive_o
);

  localparam int PKP_W = dpds_pkg::GAIN_W + 1 + dpds_pkg::ERR_W;
  localparam int PKI_W = dpds_pkg::GAIN_W + 1 + dpds_pkg::INT_W;
  localparam int PKD_W = dpds_pkg::GAIN_W + 1 + dpds_pkg::DER_W;

  logic [dpds_pkg::ENC_BITS-1:0]        enc_u;
  logic [dpds_pkg::ENC_BITS-1:0]        mag;
  logic signed [dpds_pkg::ERR_W-1:0]    tgt_x;
  logic signed [dpds_pkg::ERR_W-1:0]    err;
  logic [dpds_pkg::ERR_W-1:0]           err_mag;
  logic signed [dpds_pkg::ERR_W-1:0]    prev_b;
  logic signed [dpds_pkg::INT_W-1:0]    integ_b;
  logic [dpds_pkg::STALL_W-1:0]         stall_b;
  logic [dpds_pkg::INT_W:0]             isum;
  logic signed [dpds_pkg::INT_W-1:0]    integ_sat;
  logic signed [dpds_pkg::INT_W-1:0]    integ_nx;
  logic signed [dpds_pkg::DER_W-1:0]    der;
  logic                                 small_der;
  logic                                 stall_cond;
  logic [dpds_pkg::STALL_W-1:0]         stall_nx;

  logic signed [dpds_pkg::ERR_W-1:0]    prev_q, prev_d;
  logic signed [dpds_pkg::INT_W-1:0]    integ_q, integ_d;
  logic [dpds_pkg::STALL_W-1:0]         stall_q, stall_d;

  logic signed [dpds_pkg::ERR_W-1:0]    err_s1_q;
  logic signed [dpds_pkg::INT_W-1:0]    integ_s1_q;
  logic signed [dpds_pkg::DER_W-1:0]    der_s1_q;

  logic signed [PKP_W-1:0]              pkp_d, pkp_q;
  logic signed [PKI_W-1:0]              pki_d, pki_q;
  logic signed [PKD_W-1:0]              pkd_d, pkd_q;

  logic signed [dpds_pkg::SUM_W-1:0]    sum;
  logic [dpds_pkg::SUM_W-1:0]           smag;
  logic [dpds_pkg::SUM_W-1:0]           qmag;
  logic [dpds_pkg::DRV_W-1:0]           qclip;

  // Absolute count and error against the target
  assign enc_u = enc_i;
  assign mag   = enc_u[dpds_pkg::ENC_BITS-1] ? (~enc_u + dpds_pkg::ENC_BITS'(1)) : enc_u;
  assign tgt_x = $signed({{(dpds_pkg::ERR_W - dpds_pkg::TGT_W){1'b0}}, tgt_i});
  assign err   = tgt_x - $signed({1'b0, mag});
  assign err_mag = err[dpds_pkg::ERR_W-1] ? (~err + dpds_pkg::ERR_W'(1)) : err;

  // A new move starts from a clean state
  assign prev_b  = ctrl_i.start ? tgt_x : prev_q;
  assign integ_b = ctrl_i.start ? '0 : integ_q;
  assign stall_b = ctrl_i.start ? '0 : stall_q;

  // Saturating integral, cleared while the error is small
  assign isum = {integ_b[dpds_pkg::INT_W-1], integ_b}
              + {{(dpds_pkg::INT_W + 1 - dpds_pkg::ERR_W){err[dpds_pkg::ERR_W-1]}}, err};

  always_comb begin
    if (isum[dpds_pkg::INT_W] != isum[dpds_pkg::INT_W-1]) begin
      integ_sat = isum[dpds_pkg::INT_W] ? {1'b1, {(dpds_pkg::INT_W-1){1'b0}}}
                                        : {1'b0, {(dpds_pkg::INT_W-1){1'b1}}};
    end else begin
      integ_sat = isum[dpds_pkg::INT_W-1:0];
    end
  end

  assign integ_nx = (err_mag < {{(dpds_pkg::ERR_W - dpds_pkg::LIM_W){1'b0}}, gain_i.lim})
                  ? '0 : integ_sat;

  // Derivative and stall count
  assign der = {err[dpds_pkg::ERR_W-1], err} - {prev_b[dpds_pkg::ERR_W-1], prev_b};
  assign small_der = (der == '0) || (der == dpds_pkg::DER_W'(1)) || (der == '1);
  assign stall_cond = (err < $signed(dpds_pkg::ERR_W'(dpds_pkg::STALL_ERR))) && small_der;
  assign stall_nx = (stall_cond && (stall_b != dpds_pkg::STALL_W'(dpds_pkg::STALL_MAX)))
                  ? stall_b + dpds_pkg::STALL_W'(1) : stall_b;

  assign stat_o.reach = ({{(dpds_pkg::ENC_BITS - dpds_pkg::TGT_W){1'b0}}, tgt_i} <= mag);
  assign stat_o.trip  = (stall_nx > dpds_pkg::STALL_W'(dpds_pkg::STALL_TRIP));
  assign stat_o.err   = err;

  // Lane state update
  always_comb begin
    prev_d  = prev_q;
    integ_d = integ_q;
    stall_d = stall_q;
    if (ctrl_i.load && ctrl_i.run) begin
      prev_d  = err;
      integ_d = integ_nx;
      stall_d = stall_nx;
    end else if (ctrl_i.load && ctrl_i.start) begin
      prev_d  = prev_b;
      integ_d = integ_b;
      stall_d = stall_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      integ_q <= '0;
      stall_q <= '0;
    end else begin
      prev_q  <= prev_d;
      integ_q <= integ_d;
      stall_q <= stall_d;
    end
  end

  // First stage: error terms
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en1) begin
      err_s1_q   <= err;
      integ_s1_q <= integ_nx;
      der_s1_q   <= der;
    end
  end

  // Second stage: the three products
  assign pkp_d = $signed({1'b0, gain_i.kp}) * err_s1_q;
  assign pki_d = $signed({1'b0, gain_i.ki}) * integ_s1_q;
  assign pkd_d = $signed({1'b0, gain_i.kd}) * der_s1_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en2) begin
      pkp_q <= pkp_d;
      pki_q <= pki_d;
      pkd_q <= pkd_d;
    end
  end

  // Sum, truncate toward zero, clip
  assign sum  = dpds_pkg::SUM_W'(pkp_q) + dpds_pkg::SUM_W'(pki_q) + dpds_pkg::SUM_W'(pkd_q);
  assign smag = sum[dpds_pkg::SUM_W-1] ? (~sum + dpds_pkg::SUM_W'(1)) : sum;
  assign qmag = smag >> dpds_pkg::GAIN_FRAC_BITS;

  always_comb begin
    if (sum[dpds_pkg::SUM_W-1]) begin
      qclip = (qmag > dpds_pkg::SUM_W'(dpds_pkg::DRV_NEG_MAX))
            ? dpds_pkg::DRV_W'(dpds_pkg::DRV_NEG_MAX) : qmag[dpds_pkg::DRV_W-1:0];
    end else begin
      qclip = (qmag > dpds_pkg::SUM_W'(dpds_pkg::DRV_POS_MAX))
            ? dpds_pkg::DRV_W'(dpds_pkg::DRV_POS_MAX) : qmag[dpds_pkg::DRV_W-1:0];
    end
  end

  assign drive_o = sum[dpds_pkg::SUM_W-1] ? $signed(~qclip + dpds_pkg::DRV_W'(1))
                                          : $signed(qclip);

endmodule

>>> src/dual_pid_drive_straight.sv
// Channel   Dir  Handshake                 Payload
// s_*       in   s_tvalid / s_tready       start_move, enc_left, enc_right
// m_*       out  m_tvalid / m_tready       drive_left, drive_right, move_done, arm_raise,
//                                          pincher_hold
// cfg_*     in   cfg_valid_i / cfg_ready_o register index, write data
//
// One item per cycle while the result stream is not stalled. A result passes through, in order, the
// input register, error/state stage, product stage and result register.
// Integral, previous error and stall count feed back within the error stage.
// Reset clears lane state and leaves the move finished until start_move.
// Each stage moves when the one after it is empty or moving, so a held
// result does not block items behind it until the pipe is full.
module dual_pid_drive_straight (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // [0] start_move, [20:1] enc_left, [40:21] enc_right, rest zero
  input  logic [dpds_pkg::IN_W-1:0]         s_tdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [7:0] drive_left, [15:8] drive_right, [16] move_done, [17] arm_raise,
  // [18] pincher_hold, rest zero
  output logic [dpds_pkg::OUT_W-1:0]        m_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dpds_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dpds_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int EB = dpds_pkg::ENC_BITS;

  // Configuration
  logic [dpds_pkg::TGT_W-1:0] target_q;
  logic                       fwd_q, lift_q, hold_q;

  // Pipeline control
  logic v0_q, v1_q, v2_q, v3_q;
  logic en0, en1, en2, en3;

  // Input register
  logic                              start_s0_q;
  logic signed [EB-1:0]              enc_l_s0_q, enc_r_s0_q;

  // Move state
  logic fin_q, fin_d, fin_b;
  logic reached, run;

  logic idle1_q, arm1_q, hold1_q;
  logic idle2_q, arm2_q, hold2_q;
  logic arm1_d, hold1_d;

  // Result register
  logic signed [dpds_pkg::DRV_W-1:0] drv_l_q, drv_r_q;
  logic                              done_q, arm_q, pinch_q;

  dpds_pkg::band_e       band;
  dpds_pkg::lane_gain_t  gain_l, gain_r;
  dpds_pkg::lane_ctrl_t  ctrl;
  dpds_pkg::lane_stat_t  stat_l, stat_r;
  logic signed [dpds_pkg::DRV_W-1:0] q_l, q_r;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      fwd_q    <= 1'b1;
      lift_q   <= 1'b0;
      hold_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dpds_pkg::REG_TARGET: target_q <= cfg_data_i[dpds_pkg::TGT_W-1:0];
        dpds_pkg::REG_FWD:    fwd_q    <= cfg_data_i[0];
        dpds_pkg::REG_LIFT:   lift_q   <= cfg_data_i[0];
        dpds_pkg::REG_HOLD:   hold_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Stage enables
  assign en3 = !v3_q || m_tready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign s_tready = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en0) v0_q <= s_tvalid;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && s_tvalid) begin
      start_s0_q <= s_tdata[0];
      enc_l_s0_q <= $signed(s_tdata[EB:1]);
      enc_r_s0_q <= $signed(s_tdata[2*EB:EB+1]);
    end
  end

  // Gains follow the target band
  assign band   = dpds_pkg::band_of(target_q);
  assign gain_l = dpds_pkg::gain_left(band);
  assign gain_r = dpds_pkg::gain_right(band);

  // Move sequencing
  assign fin_b   = start_s0_q ? 1'b0 : fin_q;
  assign reached = stat_l.reach && stat_r.reach;
  assign run     = !fin_b && !reached;
  assign fin_d   = fin_b || reached || (run && (stat_l.trip || stat_r.trip));

  assign ctrl.start = start_s0_q;
  assign ctrl.run   = run;
  assign ctrl.load  = v0_q && en1;
  assign ctrl.en1   = en1;
  assign ctrl.en2   = en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= 1'b1;
    end else if (ctrl.load) begin
      fin_q <= fin_d;
    end
  end

  dpds_lane u_lane_l (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .tgt_i   (target_q),
    .enc_i   (enc_l_s0_q),
    .gain_i  (gain_l),
    .stat_o  (stat_l),
    .drive_o (q_l)
  );

  dpds_lane u_lane_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .tgt_i   (target_q),
    .enc_i   (enc_r_s0_q),
    .gain_i  (gain_r),
    .stat_o  (stat_r),
    .drive_o (q_r)
  );

  // Flags from the right lane error
  assign arm1_d  = lift_q && (stat_r.err < $signed(dpds_pkg::ERR_W'(dpds_pkg::ARM_ERR)));
  assign hold1_d = hold_q && (stat_r.err > $signed(dpds_pkg::ERR_W'(dpds_pkg::HOLD_ERR)));

  always_ff @(posedge clk_i) begin
    if (en1) begin
      idle1_q <= fin_d;
      arm1_q  <= arm1_d;
      hold1_q <= hold1_d;
    end
    if (en2) begin
      idle2_q <= idle1_q;
      arm2_q  <= arm1_q;
      hold2_q <= hold1_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (en3) begin
      if (idle2_q) begin
        drv_l_q <= '0;
        drv_r_q <= '0;
      end else begin
        drv_l_q <= fwd_q ? q_l : -q_l;
        drv_r_q <= fwd_q ? q_r : -q_r;
      end
      done_q  <= idle2_q;
      arm_q   <= !idle2_q && arm2_q;
      pinch_q <= !idle2_q && hold2_q;
    end
  end

  assign m_tvalid = v3_q;
  assign m_tdata  = {5'b0, pinch_q, arm_q, done_q, drv_r_q, drv_l_q};

endmodule

>>> src/dpds_checker.sv
// Port-level checks on the result stream
module dpds_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic [dpds_pkg::OUT_W-1:0]  m_tdata,
  input logic                        m_tvalid,
  input logic                        m_tready
);

  // A held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A finished move drives nothing and raises no flag
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[16] |-> (m_tdata[15:0] == 16'h0) && (m_tdata[18:17] == 2'b00))
    else $error("drive or flag set with move_done");

  // Drives stay within -127..127
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (m_tdata[7:0] != 8'h80) && (m_tdata[15:8] != 8'h80))
    else $error("drive out of range");

  // Padding bits are zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (m_tdata[23:19] == 5'b0))
    else $error("padding bits set");

endmodule

bind dual_pid_drive_straight dpds_checker u_dpds_checker (.*);
